// ===== hw/rtl/wlrl_pkg.sv =====
// Shared types, constants and the CRC-8 step function of the wear-leveled ring log.
package wlrl_pkg;

   localparam int SLOT_COUNT_DEF = 128;

   localparam logic       KIND_APPEND = 1'b0;
   localparam logic       KIND_READ   = 1'b1;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_INIT    = 8'h00;
   localparam logic [7:0] COUNT_INIT  = 8'hFF;
   localparam logic [7:0] SPREAD_LIM  = 8'd128;
   localparam logic [15:0] BAD_VALUE  = 16'hFFFF;

   typedef struct packed {
      logic        kind;
      logic [15:0] sample_value;
      logic [7:0]  slot_index;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        read_ok;
      logic [7:0]  next_slot;
      logic [23:0] total_samples;
      logic        full_flag;
      logic        overwrite_flag;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic cnt_rd;
      logic crc_lo;
      logic commit;
      logic scan_init;
      logic scan_rd;
      logic resolve;
      logic rec_rd;
      logic check;
      logic out_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_read;
      logic idx_bad;
      logic scan_last;
      logic out_free;
   } dp_sts_type;

   // One byte of CRC-8, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/wlrl_req_if.sv =====
// Request channel interface: valid, ready and the request payload.
interface wlrl_req_if;
   import wlrl_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/wlrl_rsp_if.sv =====
// Response channel interface: valid, ready and the response payload.
interface wlrl_rsp_if;
   import wlrl_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/wlrl_ctrl.sv =====
// Sequencing state machine of the ring log: append, rescan, read and response steps.
module wlrl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wlrl_pkg::dp_sts_type  sts,
   output wlrl_pkg::dp_cmd_type  cmd
);
   import wlrl_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_W_CNT   = 4'd1;
   localparam logic [3:0] ST_W_COMMIT = 4'd2;
   localparam logic [3:0] ST_S_INIT  = 4'd3;
   localparam logic [3:0] ST_S_SCAN  = 4'd4;
   localparam logic [3:0] ST_S_DRAIN = 4'd5;
   localparam logic [3:0] ST_S_RESOLVE = 4'd6;
   localparam logic [3:0] ST_R_ADDR  = 4'd7;
   localparam logic [3:0] ST_R_CRC   = 4'd8;
   localparam logic [3:0] ST_R_CHECK = 4'd9;
   localparam logic [3:0] ST_OUT     = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = (sts.in_read == KIND_READ) ? ST_R_ADDR : ST_W_CNT;
            end
         end
         ST_W_CNT: begin
            cmd.cnt_rd = 1'b1;
            cmd.crc_lo = 1'b1;
            state_in   = ST_W_COMMIT;
         end
         ST_W_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_S_INIT;
         end
         ST_S_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_S_SCAN;
         end
         ST_S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_S_DRAIN;
            end
         end
         ST_S_DRAIN: begin
            state_in = ST_S_RESOLVE;
         end
         ST_S_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = ST_OUT;
         end
         ST_R_ADDR: begin
            if (sts.idx_bad) begin
               state_in = ST_OUT;
            end else begin
               cmd.rec_rd = 1'b1;
               state_in   = ST_R_CRC;
            end
         end
         ST_R_CRC: begin
            cmd.crc_lo = 1'b1;
            state_in   = ST_R_CHECK;
         end
         ST_R_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/wlrl_dpath.sv =====
// Datapath of the ring log: counter and record memories, min/max scan, CRC and response register.
module wlrl_dpath #(
   parameter int SLOT_COUNT = wlrl_pkg::SLOT_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wlrl_pkg::dp_cmd_type       cmd,
   output wlrl_pkg::dp_sts_type       sts,
   input  wlrl_pkg::req_payload_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output wlrl_pkg::rsp_payload_type  rsp_data
);
   import wlrl_pkg::*;

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [AW-1:0] LAST_SLOT  = AW'(SLOT_COUNT - 1);
   localparam logic [8:0]    SLOTS_W9   = 9'(SLOT_COUNT);
   localparam logic [23:0]   SLOTS_W24  = 24'(SLOT_COUNT);

   logic [7:0]  cnt_mem [SLOT_COUNT];
   logic [23:0] rec_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] live_ff;

   req_payload_type req_ff;
   logic [AW-1:0] next_ff;
   logic [AW-1:0] next_in;
   logic [15:0]   pass_ff;
   logic [AW-1:0] scan_addr_ff;
   logic [7:0]    cnt_q_ff;
   logic [23:0]   rec_q_ff;
   logic          cmp_en_ff;
   logic [AW-1:0] cmp_idx_ff;
   logic [7:0]    min_val_ff;
   logic [7:0]    max_val_ff;
   logic [AW-1:0] min_idx_ff;
   logic [AW-1:0] max_idx_ff;
   logic [7:0]    crc_ff;
   logic [15:0]   res_value_ff;
   logic          res_ok_ff;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [AW-1:0] cnt_addr;
   logic [8:0]    sum9;
   logic [8:0]    phys9;
   logic [AW-1:0] phys;
   logic [7:0]    crc_hi;
   logic [7:0]    spread;
   logic [AW-1:0] pick;
   logic [23:0]   total;

   // Physical slot of an age-ordered read: next slot plus index, wrapped once
   assign sum9  = {1'b0, 8'(next_ff)} + {1'b0, req_ff.slot_index};
   assign phys9 = (sum9 >= SLOTS_W9) ? (sum9 - SLOTS_W9) : sum9;
   assign phys  = phys9[AW-1:0];

   assign cnt_addr = cmd.scan_rd ? scan_addr_ff : next_ff;
   assign crc_hi   = crc8_byte(crc_ff, req_ff.sample_value[15:8]);

   // Next slot from the finished min/max scan
   always_comb begin
      spread = max_val_ff - min_val_ff;
      pick   = (spread < SPREAD_LIM) ? max_idx_ff : min_idx_ff;
      if (min_val_ff == max_val_ff) begin
         next_in = '0;
      end else if (pick == LAST_SLOT) begin
         next_in = '0;
      end else begin
         next_in = pick + AW'(1);
      end
   end

   // Memories: one read and one write port each, read data registered
   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.cnt_rd) begin
         cnt_q_ff <= live_ff[cnt_addr] ? cnt_mem[cnt_addr] : 8'h00;
      end
      if (cmd.rec_rd) begin
         rec_q_ff <= live_ff[phys] ? rec_mem[phys] : 24'h000000;
      end
      if (cmd.commit) begin
         cnt_mem[next_ff] <= cnt_q_ff + 8'd1;
         rec_mem[next_ff] <= {crc_hi, req_ff.sample_value};
      end
   end

   // Written-slot flags stand in for the cleared memories
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (cmd.commit) begin
         live_ff[next_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.scan_init) begin
         min_val_ff <= COUNT_INIT;
         max_val_ff <= 8'h00;
         min_idx_ff <= '0;
         max_idx_ff <= '0;
      end else if (cmp_en_ff) begin
         if (cnt_q_ff <= min_val_ff) begin
            min_val_ff <= cnt_q_ff;
            min_idx_ff <= cmp_idx_ff;
         end
         if (cnt_q_ff >= max_val_ff) begin
            max_val_ff <= cnt_q_ff;
            max_idx_ff <= cmp_idx_ff;
         end
      end
      if (cmd.scan_init) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
      end
      cmp_idx_ff <= scan_addr_ff;
      if (cmd.crc_lo) begin
         crc_ff <= crc8_byte(CRC_INIT, (req_ff.kind == KIND_READ) ?
                             rec_q_ff[7:0] : req_ff.sample_value[7:0]);
      end
      if (cmd.load_req) begin
         res_value_ff <= BAD_VALUE;
         res_ok_ff    <= 1'b0;
      end else if (cmd.check) begin
         if (crc8_byte(crc_ff, rec_q_ff[15:8]) == rec_q_ff[23:16]) begin
            res_value_ff <= rec_q_ff[15:0];
            res_ok_ff    <= 1'b1;
         end
      end
      if (cmd.out_load) begin
         rsp_data_ff.read_value     <= res_value_ff;
         rsp_data_ff.read_ok        <= res_ok_ff;
         rsp_data_ff.next_slot      <= 8'(next_ff);
         rsp_data_ff.total_samples  <= total;
         rsp_data_ff.full_flag      <= (total >= SLOTS_W24);
         rsp_data_ff.overwrite_flag <= (total > SLOTS_W24);
      end
   end

   assign total = 24'({8'h00, pass_ff} * SLOTS_W24) + 24'(next_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff      <= '0;
         pass_ff      <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.scan_rd;
         if (cmd.resolve) begin
            next_ff <= next_in;
         end
         // Rewriting a used slot 0 opens a new pass
         if (cmd.commit && (next_ff == '0) && (cnt_q_ff != 8'h00)) begin
            pass_ff <= pass_ff + 16'd1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.in_read   = req_data.kind;
   assign sts.idx_bad   = ({1'b0, req_ff.slot_index} >= SLOTS_W9);
   assign sts.scan_last = (scan_addr_ff == LAST_SLOT);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/wear_leveled_ring_log_top.sv =====
// Top level of the wear-leveled ring log: controller, datapath and channel wiring.
//
//   channel   dir   handshake            payload
//   req_bus   in    valid/ready          kind, sample_value, slot_index
//   rsp_bus   out   valid/ready          read_value, read_ok, next_slot, total_samples,
//                                        full_flag, overwrite_flag
//
// One request at a time. An append runs the counter read-modify-write, then a full scan
// of the counter memory (one counter per cycle through its single read port) to pick the
// next slot. A read runs a record read, two CRC byte steps and the response load; an
// out-of-range slot index goes straight to the response load.
// Reset clears the pass count, the next slot and the per-slot written flags, so all slots
// read as zero counters and zero records at once; no clearing sweep.
// The response register decouples the sides: a new request is accepted while the previous
// response still waits; its own response is loaded once the register is free.
module wear_leveled_ring_log_top #(
   parameter int SLOT_COUNT = wlrl_pkg::SLOT_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   wlrl_req_if.sink   req_bus,
   wlrl_rsp_if.source rsp_bus
);
   import wlrl_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequence each request
   wlrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the memories, scan and response register
   wlrl_dpath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_bus.payload),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_bus.payload)
   );

endmodule
